// File: src/tsms_pkg.sv
// Shared constants and types for the timestamp text to milliseconds block.
// No dependencies; imported by every module in src.
package tsms_pkg;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_COLON = 8'd58;

  // Limits
  localparam logic [1:0] INT_DIGITS = 2'd2;
  localparam logic [1:0] MAX_COLONS = 2'd3;
  localparam logic [2:0] GROUP_LIMIT = 3'd4;
  localparam logic [2:0] GROUPS_NO_DEC = 3'd3;
  localparam logic [2:0] GROUP_OVERFLOW = 3'd5;

  // Weights in milliseconds
  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
  localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
  localparam logic [31:0] MILLIS_TOP    = 32'd2147483647;

  // Configuration register indexes
  localparam logic CFG_DECIMAL_SYMBOL = 1'b0;
  localparam logic CFG_MAX_FRAC       = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0] DECIMAL_SYMBOL_RST = 7'd44;
  localparam logic [1:0] MAX_FRAC_RST       = 2'd3;

  localparam int GRP_W = 10;

  // Final parse state of one timestamp, handed from parser to scaler
  typedef struct packed {
    logic                        ok;   // text well formed
    logic                        dec;  // decimal symbol seen
    logic [3:0][GRP_W-1:0]       grp;  // digit-run values, [0] newest
  } tsms_snap_t;

endpackage

// File: src/tsms_parser.sv
// Character parser: classifies each byte, tracks groups and separators.
// On the final byte it hands a snapshot of the parse to the scaler.
// Depends on tsms_pkg.
module tsms_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              chr_valid,
  output logic              chr_ready,
  input  logic [7:0]        chr_code,
  input  logic              chr_last,
  input  logic [6:0]        cfg_decimal_symbol,
  input  logic [1:0]        cfg_max_frac,
  output logic              snap_valid,
  input  logic              snap_ready,
  output tsms_pkg::tsms_snap_t snap
);
  import tsms_pkg::*;

  logic [3:0][GRP_W-1:0] grp_r, grp_nxt;
  logic [2:0]            gcnt_r, gcnt_nxt;
  logic [1:0]            run_r, run_nxt;
  logic [1:0]            ccnt_r, ccnt_nxt;
  logic                  dec_r, dec_nxt;
  logic                  err_r, err_nxt;
  logic                  snap_v_r;
  tsms_snap_t            snap_r;

  logic [1:0]       limit;
  logic [2:0]       run_inc;
  logic [GRP_W-1:0] base;
  logic [13:0]      acc;
  logic             is_digit, is_colon, is_decsym;
  logic             ok;
  logic             take;
  logic             slot_free;

  assign is_digit  = (chr_code >= CHAR_ZERO) && (chr_code <= CHAR_NINE);
  assign is_colon  = (chr_code == CHAR_COLON);
  assign is_decsym = !chr_code[7] && (chr_code[6:0] == cfg_decimal_symbol);

  assign limit   = dec_r ? cfg_max_frac : INT_DIGITS;
  assign run_inc = {1'b0, run_r} + 3'd1;
  assign base    = (run_r == 2'd0) ? '0 : grp_r[0];
  // value * 10 + digit
  assign acc     = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {10'd0, chr_code[3:0]};

  always_comb begin
    grp_nxt  = grp_r;
    gcnt_nxt = gcnt_r;
    run_nxt  = run_r;
    ccnt_nxt = ccnt_r;
    dec_nxt  = dec_r;
    err_nxt  = err_r;
    if (!err_r) begin
      if (is_digit) begin
        if (run_inc > {1'b0, limit}) begin
          err_nxt = 1'b1;
        end else if ((run_r == 2'd0) && (gcnt_r >= GROUP_LIMIT)) begin
          gcnt_nxt = GROUP_OVERFLOW;
          err_nxt  = 1'b1;
        end else begin
          if (run_r == 2'd0) begin
            grp_nxt[3] = grp_r[2];
            grp_nxt[2] = grp_r[1];
            grp_nxt[1] = grp_r[0];
            gcnt_nxt   = gcnt_r + 3'd1;
          end
          grp_nxt[0] = acc[GRP_W-1:0];
          run_nxt    = run_inc[1:0];
        end
      end else if (is_colon) begin
        run_nxt = 2'd0;
        if (ccnt_r >= MAX_COLONS) begin
          err_nxt = 1'b1;
        end else begin
          ccnt_nxt = ccnt_r + 2'd1;
        end
      end else if (is_decsym) begin
        run_nxt = 2'd0;
        if (dec_r) begin
          err_nxt = 1'b1;
        end else begin
          dec_nxt = 1'b1;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  assign ok = !err_nxt && (gcnt_nxt <= GROUP_LIMIT) && (dec_nxt || (gcnt_nxt <= GROUPS_NO_DEC));

  // A final byte needs room in the snapshot slot; other bytes always go.
  assign slot_free = !snap_v_r || snap_ready;
  assign chr_ready = !chr_last || slot_free;
  assign take      = chr_valid && chr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r    <= '0;
      gcnt_r   <= '0;
      run_r    <= '0;
      ccnt_r   <= '0;
      dec_r    <= 1'b0;
      err_r    <= 1'b0;
      snap_v_r <= 1'b0;
    end else begin
      if (take && chr_last) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
      if (take) begin
        if (chr_last) begin
          grp_r    <= '0;
          gcnt_r   <= '0;
          run_r    <= '0;
          ccnt_r   <= '0;
          dec_r    <= 1'b0;
          err_r    <= 1'b0;
        end else begin
          grp_r    <= grp_nxt;
          gcnt_r   <= gcnt_nxt;
          run_r    <= run_nxt;
          ccnt_r   <= ccnt_nxt;
          dec_r    <= dec_nxt;
          err_r    <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && chr_last) begin
      snap_r.ok  <= ok;
      snap_r.dec <= dec_nxt;
      snap_r.grp <= grp_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

// File: src/tsms_scaler.sv
// Scaler: weights the digit groups by constant factors, sums and saturates.
// Holds the result register. Depends on tsms_pkg.
module tsms_scaler (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              snap_valid,
  output logic              snap_ready,
  input  tsms_pkg::tsms_snap_t snap,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              res_is_valid,
  output logic [30:0]       res_millis
);
  import tsms_pkg::*;

  logic        res_v_r;
  logic        is_valid_r;
  logic [30:0] millis_r;
  logic [31:0] g0, g1, g2, g3;
  logic [31:0] sum;
  logic [30:0] sat;

  assign g0 = {22'd0, snap.grp[0]};
  assign g1 = {22'd0, snap.grp[1]};
  assign g2 = {22'd0, snap.grp[2]};
  assign g3 = {22'd0, snap.grp[3]};

  // Without a decimal symbol the newest group is seconds and group 3 is empty.
  always_comb begin
    if (snap.dec) begin
      sum = g0 + g1 * MS_PER_SECOND + g2 * MS_PER_MINUTE + g3 * MS_PER_HOUR;
    end else begin
      sum = g0 * MS_PER_SECOND + g1 * MS_PER_MINUTE + g2 * MS_PER_HOUR;
    end
  end

  assign sat        = (sum > MILLIS_TOP) ? MILLIS_TOP[30:0] : sum[30:0];
  assign snap_ready = !res_v_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (snap_ready) begin
      res_v_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      is_valid_r <= snap.ok;
      millis_r   <= snap.ok ? sat : '0;
    end
  end

  assign res_valid    = res_v_r;
  assign res_is_valid = is_valid_r;
  assign res_millis   = millis_r;

endmodule

// File: src/timestamp_text_to_milliseconds.sv
// Top level: subtitle timestamp text to milliseconds.
// Instantiates tsms_parser and tsms_scaler; depends on tsms_pkg.
//
//  channel | direction | accepted when           | contents
//  in_     | slave     | in_tvalid & in_tready   | tdata = char_code, tlast = is_last
//  out_    | master    | out_tvalid & out_tready | tdata = {millis, is_valid}
//  cfg_    | write     | cfg_we                  | cfg_index selects, cfg_wdata value
//
// One character is taken per cycle; only final characters wait on the result
// side, other characters flow into the parser state even while the output
// stalls. A final character passes the input register, the parser snapshot
// register and the result register before its result is valid.
// Reset (rst_n low, synchronous) clears all parse state and the valid flags
// and loads the default configuration: ',' as decimal symbol, 3 fraction digits.
module timestamp_text_to_milliseconds (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] is_valid, [31:1] millis
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import tsms_pkg::*;

  logic       in_v_r;
  logic [7:0] chr_r;
  logic       last_r;
  logic       chr_ready;

  logic [6:0] decimal_symbol_r;
  logic [1:0] max_frac_r;

  logic       snap_valid;
  logic       snap_ready;
  tsms_snap_t snap;

  logic        res_is_valid;
  logic [30:0] res_millis;

  // Config registers; written only while the block is idle: a user rule, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimal_symbol_r <= DECIMAL_SYMBOL_RST;
      max_frac_r       <= MAX_FRAC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECIMAL_SYMBOL: decimal_symbol_r <= cfg_wdata;
        CFG_MAX_FRAC:       max_frac_r       <= cfg_wdata[1:0];
        default:            ;
      endcase
    end
  end

  // Input register: refills in the same cycle it drains.
  assign in_tready = !in_v_r || chr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      chr_r  <= in_tdata;
      last_r <= in_tlast;
    end
  end

  tsms_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .chr_valid          (in_v_r),
    .chr_ready          (chr_ready),
    .chr_code           (chr_r),
    .chr_last           (last_r),
    .cfg_decimal_symbol (decimal_symbol_r),
    .cfg_max_frac       (max_frac_r),
    .snap_valid         (snap_valid),
    .snap_ready         (snap_ready),
    .snap               (snap)
  );

  tsms_scaler u_scaler (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_is_valid (res_is_valid),
    .res_millis   (res_millis)
  );

  assign out_tdata = {res_millis, res_is_valid};

endmodule

// File: tb/timestamp_text_to_milliseconds_tb.sv
// Self-checking testbench for timestamp_text_to_milliseconds: character
// stream in, millisecond results out, checked against an in-bench predictor.
// Depends on tsms_pkg and the RTL under src; needs nothing else.
module timestamp_text_to_milliseconds_tb;
  import tsms_pkg::*;

  // One pending input transaction; wait_drain holds it back until every
  // result already predicted has been received.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       wait_drain;
  } char_item_t;

  // One predicted output transaction
  typedef struct packed {
    logic        ok;
    logic [30:0] ms;
  } stamp_result_t;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 10;      // pipeline is three deep; allow margin
  localparam int LONG_STALL   = 400;     // receiver hold-off, in cycles
  localparam int PHASE_CHARS  = 150;     // random characters per phase
  localparam int RUN_LIMIT    = 4000000; // time units before giving up

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;          // [7:0] char_code
  logic        in_tlast   = 1'b0;        // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;                // [0] is_valid, [31:1] millis
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [6:0]  cfg_wdata  = '0;

  // Stimulus and scoreboard stores
  char_item_t    pending_chars[$];
  stamp_result_t expected_stamps[$];
  int            mismatches   = 0;
  logic          drain_next   = 1'b0;

  // Handshake pressure, per cent of cycles idle on each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req     = 0;   // bumped by the sequencer to ask for a long stall
  int stall_seen    = 0;   // monitor-owned
  int stall_left    = 0;   // monitor-owned

  // Bench copy of the configuration
  logic [6:0] dec_sym  = DECIMAL_SYMBOL_RST;
  logic [1:0] max_frac = MAX_FRAC_RST;

  // Bench copy of the per-text parse state
  logic [GRP_W-1:0] grp_val [4] = '{default: '0};
  logic [2:0]       grp_cnt  = '0;
  logic [1:0]       run_len  = '0;
  logic [1:0]       colons   = '0;
  logic             dec_seen = 1'b0;
  logic             bad      = 1'b0;

  timestamp_text_to_milliseconds DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor: fold one accepted character into the parse state; on the
  // final character push the expected result and clear the text state.
  task automatic track_char(input logic [7:0] c, input logic last);
    int              lim;
    int              n;
    int              acc;
    int              off;
    int              k;
    longint unsigned w;
    longint unsigned sum;
    stamp_result_t   r;
    if (!bad) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        // two digits per run, or the fraction limit once the symbol is seen
        lim = dec_seen ? int'(max_frac) : int'(INT_DIGITS);
        n   = int'(run_len) + 1;
        if (n > lim) begin
          bad = 1'b1;
        end else if (run_len == 0 && grp_cnt >= GROUP_LIMIT) begin
          grp_cnt = GROUP_OVERFLOW;
          bad     = 1'b1;
        end else begin
          if (run_len == 0) begin
            grp_val[3] = grp_val[2];
            grp_val[2] = grp_val[1];
            grp_val[1] = grp_val[0];
            grp_val[0] = '0;
            grp_cnt    = grp_cnt + 3'd1;
          end
          acc        = int'(grp_val[0]) * 10 + int'(c - CHAR_ZERO);
          grp_val[0] = acc[GRP_W-1:0];
          run_len    = n[1:0];
        end
      end else if (c == CHAR_COLON) begin
        run_len = '0;
        if (colons >= MAX_COLONS) bad = 1'b1;
        else colons = colons + 2'd1;
      end else if (c == {1'b0, dec_sym}) begin
        // digit and colon meaning win; top-half bytes never match
        run_len = '0;
        if (dec_seen) bad = 1'b1;
        else dec_seen = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end
    if (last) begin
      r.ok = !bad && grp_cnt <= GROUP_LIMIT && (dec_seen || grp_cnt <= GROUPS_NO_DEC);
      sum  = 0;
      if (r.ok) begin
        // newest group weighs 1 ms with a fraction, 1 s without
        off = dec_seen ? 0 : 1;
        for (k = 0; k < int'(grp_cnt) && k + off < 4; k++) begin
          case (k + off)
            0:       w = 1;
            1:       w = MS_PER_SECOND;
            2:       w = MS_PER_MINUTE;
            default: w = MS_PER_HOUR;
          endcase
          sum += w * grp_val[k];
        end
        if (sum > MILLIS_TOP) sum = MILLIS_TOP;
      end
      r.ms = sum[30:0];
      expected_stamps.push_back(r);
      grp_val  = '{default: '0};
      grp_cnt  = '0;
      run_len  = '0;
      colons   = '0;
      dec_seen = 1'b0;
      bad      = 1'b0;
    end
  endtask

  // Driver: one input transaction per free slot, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_char(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 &&
            !(pending_chars[0].wait_drain && expected_stamps.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata  <= pending_chars[0].ch;
          in_tlast  <= pending_chars[0].last;
          in_tvalid <= 1'b1;
          void'(pending_chars.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, drive tready with random gaps
  // and the occasional long hold-off that backs the block up.
  always @(posedge clk) begin
    stamp_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_stamps.size() == 0) begin
          $display("%0t: unexpected result, actual is_valid=%0b millis=%0d",
                   $time, out_tdata[0], out_tdata[31:1]);
          mismatches++;
        end else begin
          want = expected_stamps.pop_front();
          if (out_tdata[0] !== want.ok) begin
            $display("%0t: is_valid mismatch, expected %0b actual %0b",
                     $time, want.ok, out_tdata[0]);
            mismatches++;
          end
          if (out_tdata[31:1] !== want.ms) begin
            $display("%0t: millis mismatch, expected %0d actual %0d",
                     $time, want.ms, out_tdata[31:1]);
            mismatches++;
          end
        end
      end
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] rand_digit();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // Any character the parser might see: digit, colon, symbol or raw byte
  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 3))
      0:       return rand_digit();
      1:       return CHAR_COLON;
      2:       return {1'b0, dec_sym};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.ch         = c;
    it.last       = last;
    it.wait_drain = drain_next;
    drain_next    = 1'b0;
    pending_chars.push_back(it);
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed timestamps with random content, some mutated,
  // some plain noise.
  task automatic queue_random_text(inout int used);
    logic [7:0] txt[$];
    int         kind;
    int         groups;
    int         nd;
    int         g;
    int         i;
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      groups = ($urandom_range(0, 19) == 0) ? 4 : $urandom_range(1, 3);
      for (g = 0; g < groups; g++) begin
        if (g > 0) txt.push_back(CHAR_COLON);
        nd = $urandom_range(1, INT_DIGITS);
        repeat (nd) txt.push_back(rand_digit());
      end
      if ($urandom_range(0, 3) != 0) begin
        txt.push_back({1'b0, dec_sym});
        nd = $urandom_range(0, max_frac);
        repeat (nd) txt.push_back(rand_digit());
        // runs after a later colon still use the fraction limit
        if ($urandom_range(0, 7) == 0) begin
          txt.push_back(CHAR_COLON);
          nd = $urandom_range(0, max_frac);
          repeat (nd) txt.push_back(rand_digit());
        end
      end
      if (kind >= 65) begin
        i = $urandom_range(0, txt.size() - 1);
        if ($urandom_range(0, 1) == 0) txt[i] = any_char();
        else txt.insert(i, any_char());
      end
    end else begin
      nd = $urandom_range(1, 5);
      repeat (nd) txt.push_back(any_char());
    end
    for (i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
    used += txt.size();
  endtask

  // Only called when idle: both registers, then drop the write enable
  task automatic set_config(input logic [6:0] sym, input logic [1:0] frac);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DECIMAL_SYMBOL;
    cfg_wdata <= sym;
    dec_sym    = sym;
    @(posedge clk);
    cfg_index <= CFG_MAX_FRAC;
    cfg_wdata <= {5'b0, frac};
    max_frac   = frac;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until every queued transaction is in and every result is out,
  // then let the pipeline settle.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || in_tvalid || expected_stamps.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sequencer
  initial begin
    int   ph;
    int   used;
    logic drain_done;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks, sender gappy and receiver very slow
    send_idle_pct = 18;
    recv_idle_pct = 88;
    set_config(7'd44, 2'd3);
    queue_text("00:01:17,400");
    queue_text(",999:999:999:999");    // saturates at the top
    queue_text("12:34:56");            // no fraction, weights start at 1 s
    queue_text("1:2:3:4");             // fourth run without decimal
    queue_text("1:2:3,4:5");           // fifth run
    queue_text("::::");                // fourth colon
    queue_text("1,2,3");               // second decimal symbol
    queue_text("123");                 // run too long
    queue_text("1,1234");              // fraction too long
    queue_text(":");                   // no digits at all
    queue_text(",4");                  // short fraction
    queue_text("1a");                  // stray character
    queue_text("1\254");               // top-half byte never matches
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_char(CHAR_NINE, 1'b1);
    wait_idle();
    set_config(7'd48, 2'd0);           // symbol clashes with a digit
    queue_text("10:20");
    queue_text("1,2");
    wait_idle();
    set_config(7'd46, 2'd0);           // no fraction digits allowed
    queue_text(".1");
    queue_text("5.");
    wait_idle();
    set_config(7'd58, 2'd1);           // symbol clashes with the colon
    queue_text("1:2");
    wait_idle();

    // Random phases, each with its own configuration; each pair of phases shares a handshake pressure
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(7'd46, 2'd2);
        1: set_config(7'd33, 2'd0);
        2: set_config(7'd126, 2'd1);
        3: set_config(7'd44, 2'd3);
        4: set_config(7'd59, 2'd3);
        default: set_config(7'd58, 2'd2);
      endcase
      if (ph < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 88;
      end else if (ph < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // receiver holds off while the sender keeps offering
      if (ph == 4) stall_req++;
      used       = 0;
      drain_done = 1'b0;
      while (used < PHASE_CHARS) begin
        // sender pauses once until the results so far have all come back
        if ((ph == 1 || ph == 4) && used >= PHASE_CHARS / 2 && !drain_done) begin
          drain_next = 1'b1;
          drain_done = 1'b1;
        end
        queue_random_text(used);
      end
      wait_idle();
    end

    if (mismatches == 0)
      $display("timestamp_text_to_milliseconds verification clean");
    else
      $display("timestamp_text_to_milliseconds verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("timestamp_text_to_milliseconds verification failed");
    $finish;
  end

endmodule
